### hdl/rbsf_pkg.sv
// Shared types, constants and helpers for the RGBA 3x3 blur/sharpen filter.
// No dependencies; every other file but rbsf_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rbsf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W = $clog2(MAX_WIDTH);  // column counter / line store address
  localparam int WID_W = 11;                 // width register
  localparam int HGT_W = 13;                 // height register, also row counters (h+1 max)
  localparam int PIX_W = 32;
  localparam int RCP_SHIFT = 16;             // reciprocal scale for divide by 1..9

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic       action;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_last;
  } pix_out_t;

  // neighborhood clipping and end-of-frame flag for one output pixel
  typedef struct packed {
    logic emit;
    logic top;
    logic bot;
    logic lft;
    logic rgt;
    logic last;
  } tag_t;

  typedef struct packed {
    logic              wr;
    logic [COL_W-1:0]  col;
    logic [PIX_W-1:0]  px;
    tag_t              tag;
  } ctl_t;

  typedef logic [8:0][PIX_W-1:0] win_t;

  // ceil(2^16 / n); exact truncating quotient for sums below 2296
  function automatic logic [RCP_SHIFT:0] recip(input logic [3:0] n);
    logic [RCP_SHIFT:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/rbsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rbsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/rbsf_ctrl.sv
// Config registers and raster position counters; decides per transaction
// whether it updates the line store and whether it produces an output.
// Depends on rbsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbsf_ctrl import rbsf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_addr_i,
  input  wire logic [HGT_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  input  wire pix_in_t          in_data_i,
  input  wire logic             adv_i,
  output logic                  iss_vld_o,
  output ctl_t                  iss_o,
  output logic                  mode_o
);

  logic             mode_q;
  logic [WID_W-1:0] width_q;
  logic [HGT_W-1:0] height_q;
  logic [COL_W-1:0] col_q, ocol_q;
  logic [HGT_W-1:0] row_q, orow_q;

  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic             act, col0, emit, restart;
  logic [WID_W-1:0] col_inc, ocol_inc;
  logic             col_wrap, ocol_wrap;
  logic [HGT_W:0]   orow_inc;

  always_comb begin
    w_eff = width_q;
    if (width_q == '0) begin
      w_eff = WID_W'(1);
    end else if (width_q > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end
    h_eff = height_q;
    if (height_q == '0) begin
      h_eff = HGT_W'(1);
    end else if (height_q > HGT_W'(MAX_HEIGHT)) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end
  end

  // pixels count only inside the frame, drains only after it
  assign act     = (in_data_i.action == ACT_DRAIN) ? (row_q >= h_eff) : (row_q < h_eff);
  assign col0    = (col_q == '0);
  assign emit    = col0 ? (row_q >= HGT_W'(2)) : (row_q != '0);
  assign restart = col0 && (row_q > h_eff);

  assign col_inc   = {1'b0, col_q} + WID_W'(1);
  assign col_wrap  = (col_inc >= w_eff);
  assign ocol_inc  = {1'b0, ocol_q} + WID_W'(1);
  assign ocol_wrap = (ocol_inc >= w_eff);
  assign orow_inc  = {1'b0, orow_q} + (HGT_W+1)'(1);

  always_comb begin
    iss_o.wr       = !restart;
    iss_o.col      = col_q;
    iss_o.px       = {in_data_i.alpha_in, in_data_i.blue_in,
                      in_data_i.green_in, in_data_i.red_in};
    iss_o.tag.emit = emit;
    iss_o.tag.top  = (orow_q != '0);
    iss_o.tag.bot  = (orow_inc < {1'b0, h_eff});
    iss_o.tag.lft  = (ocol_q != '0);
    iss_o.tag.rgt  = !ocol_wrap;
    iss_o.tag.last = (orow_inc == {1'b0, h_eff}) && ocol_wrap;
  end

  assign iss_vld_o = in_valid_i && adv_i && act;
  assign mode_o    = mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      width_q  <= WID_W'(640);
      height_q <= HGT_W'(480);
      col_q    <= '0;
      row_q    <= '0;
      ocol_q   <= '0;
      orow_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_MODE: begin
          mode_q <= cfg_wdata_i[0];
        end
        REG_WIDTH: begin
          width_q <= cfg_wdata_i[WID_W-1:0];
          col_q   <= '0;
          row_q   <= '0;
          ocol_q  <= '0;
          orow_q  <= '0;
        end
        REG_HEIGHT: begin
          height_q <= cfg_wdata_i;
          col_q    <= '0;
          row_q    <= '0;
          ocol_q   <= '0;
          orow_q   <= '0;
        end
        default: begin
        end
      endcase
    end else if (iss_vld_o) begin
      if (restart) begin
        col_q  <= '0;
        row_q  <= '0;
        ocol_q <= '0;
        orow_q <= '0;
      end else begin
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_q + HGT_W'(1);
        end else begin
          col_q <= col_inc[COL_W-1:0];
        end
        if (emit) begin
          if (ocol_wrap) begin
            ocol_q <= '0;
            orow_q <= orow_inc[HGT_W-1:0];
          end else begin
            ocol_q <= ocol_inc[COL_W-1:0];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### hdl/rbsf_win.sv
// Two-row line store (one RAM, entry = {row above, current row}) and the
// 3x3 window registers. Depends on rbsf_pkg and rbsf_ram.
`timescale 1ns / 1ps
`default_nettype none

module rbsf_win import rbsf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic adv_i,
  input  wire logic iss_vld_i,
  input  wire ctl_t iss_i,
  output logic      vld_o,
  output win_t      win_o,
  output tag_t      tag_o
);

  logic               s1_vld_q;
  ctl_t               s1_q;
  logic               fwd_q;
  logic [2*PIX_W-1:0] fwd_data_q;
  logic [2*PIX_W-1:0] ram_rdata, rd, wdata;
  logic               ram_we;
  logic [PIX_W-1:0]   newest [3];
  win_t               win_q, win_d;
  tag_t               tag_q;
  logic               vld_q;

  assign ram_we = adv_i && s1_vld_q && s1_q.wr;

  rbsf_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.col),
    .wdata_i (wdata),
    .re_i    (iss_vld_i),
    .raddr_i (iss_i.col),
    .rdata_o (ram_rdata)
  );

  // a one-column image reads the entry being written in the same cycle
  assign rd        = fwd_q ? fwd_data_q : ram_rdata;
  assign newest[0] = rd[2*PIX_W-1:PIX_W];
  assign newest[1] = rd[PIX_W-1:0];
  assign newest[2] = s1_q.px;
  assign wdata     = {rd[PIX_W-1:0], s1_q.px};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i*3]     = win_q[i*3+1];
      win_d[i*3 + 1] = win_q[i*3+2];
      win_d[i*3 + 2] = newest[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
      vld_q    <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= iss_vld_i;
      fwd_q    <= iss_vld_i && s1_vld_q && s1_q.wr && (s1_q.col == iss_i.col);
      vld_q    <= s1_vld_q && s1_q.tag.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q       <= iss_i;
      fwd_data_q <= wdata;
      tag_q      <= s1_q.tag;
      if (s1_vld_q) begin
        win_q <= win_d;
      end
    end
  end

  assign vld_o = vld_q;
  assign win_o = win_q;
  assign tag_o = tag_q;

endmodule

`default_nettype wire

### hdl/rbsf_arith.sv
// Clipped 3x3 sum, divide by neighbor count, blur/sharpen select, output
// register. Three stages. Depends on rbsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbsf_arith import rbsf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic adv_i,
  input  wire logic mode_i,
  input  wire logic vld_i,
  input  wire win_t win_i,
  input  wire tag_t tag_i,
  output logic      out_vld_o,
  output pix_out_t  out_o
);

  localparam int PRD_W = 12 + RCP_SHIFT + 1;

  // stage A: row sums with column clipping
  logic [3:0][2:0][9:0] rs_d, rs_q;
  logic [3:0][7:0]      cen_a_q, cen_b_q;
  logic [3:0]           n_d, n_q;
  logic [1:0]           ncol, nrow;
  logic                 top_q, bot_q, last_a_q, last_b_q;
  logic                 vld_a_q, vld_b_q, out_vld_q;
  // stage B: total and reciprocal product
  logic [3:0][PRD_W-1:0] prd_d, prd_q;
  logic [11:0]           tot;
  logic [RCP_SHIFT:0]    rcp;
  // output stage
  logic [3:0][7:0]       res;
  logic [7:0]            avg;
  logic [9:0]            sv;
  pix_out_t              out_q;

  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      for (int i = 0; i < 3; i++) begin
        rs_d[ch][i] = 10'(win_i[i*3+1][8*ch +: 8])
                    + (tag_i.lft ? 10'(win_i[i*3][8*ch +: 8]) : 10'd0)
                    + (tag_i.rgt ? 10'(win_i[i*3+2][8*ch +: 8]) : 10'd0);
      end
    end
    ncol = 2'd1 + 2'(tag_i.lft) + 2'(tag_i.rgt);
    nrow = 2'd1 + 2'(tag_i.top) + 2'(tag_i.bot);
    n_d  = {2'b00, ncol} * {2'b00, nrow};
  end

  always_comb begin
    rcp = recip(n_q);
    for (int ch = 0; ch < 4; ch++) begin
      tot = 12'(rs_q[ch][1])
          + (top_q ? 12'(rs_q[ch][0]) : 12'd0)
          + (bot_q ? 12'(rs_q[ch][2]) : 12'd0);
      prd_d[ch] = PRD_W'(tot) * PRD_W'(rcp);
    end
  end

  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      avg = prd_q[ch][RCP_SHIFT +: 8];
      sv  = {1'b0, cen_b_q[ch], 1'b0} - {2'b00, avg};
      if (!mode_i) begin
        res[ch] = avg;
      end else if (sv[9]) begin
        res[ch] = 8'd0;
      end else if (sv[8]) begin
        res[ch] = 8'd255;
      end else begin
        res[ch] = sv[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q   <= 1'b0;
      vld_b_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_a_q   <= vld_i;
      vld_b_q   <= vld_a_q;
      out_vld_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rs_q     <= rs_d;
      n_q      <= n_d;
      top_q    <= tag_i.top;
      bot_q    <= tag_i.bot;
      last_a_q <= tag_i.last;
      for (int ch = 0; ch < 4; ch++) begin
        cen_a_q[ch] <= win_i[4][8*ch +: 8];
      end
      prd_q    <= prd_d;
      cen_b_q  <= cen_a_q;
      last_b_q <= last_a_q;
      out_q.red_out    <= res[0];
      out_q.green_out  <= res[1];
      out_q.blue_out   <= res[2];
      out_q.alpha_out  <= res[3];
      out_q.frame_last <= last_b_q;
    end
  end

  assign out_vld_o = out_vld_q;
  assign out_o     = out_q;

endmodule

`default_nettype wire

### hdl/rgba_3x3_blur_sharpen_filter.sv
// Top level of the streaming RGBA 3x3 box blur / sharpen filter.
// Depends on rbsf_pkg, rbsf_ctrl, rbsf_win, rbsf_arith.
//
//   channel | handshake                   | payload
//   --------+-----------------------------+-------------------------------
//   input   | in_valid_i / in_stall_o     | in_data_i  (pix_in_t)
//   output  | out_valid_o / out_stall_i   | out_data_o (pix_out_t)
//   config  | cfg_we_i                    | cfg_addr_i, cfg_wdata_i
//
// One transaction per clock while not stalled. A result passes the s1, window,
// stage A and stage B registers, then the output register; results trail the
// pixel stream by width+1 positions, pushed out at frame end by drain transactions.
// Reset clears config to mode 0, 640x480, and all position counters.
// The line store needs no clearing pass. A stalled output freezes every
// stage, and the input stalls only while the output register is full and stalled.
`timescale 1ns / 1ps
`default_nettype none

module rgba_3x3_blur_sharpen_filter import rbsf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_addr_i,
  input  wire logic [HGT_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire pix_in_t          in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output pix_out_t              out_data_o
);

  logic adv;
  logic iss_vld;
  ctl_t iss;
  logic mode;
  logic win_vld;
  win_t win;
  tag_t tag;

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  rbsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .adv_i       (adv),
    .iss_vld_o   (iss_vld),
    .iss_o       (iss),
    .mode_o      (mode)
  );

  rbsf_win u_win (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .iss_vld_i (iss_vld),
    .iss_i     (iss),
    .vld_o     (win_vld),
    .win_o     (win),
    .tag_o     (tag)
  );

  rbsf_arith u_arith (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .mode_i    (mode),
    .vld_i     (win_vld),
    .win_i     (win),
    .tag_i     (tag),
    .out_vld_o (out_valid_o),
    .out_o     (out_data_o)
  );

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output");

  a_issue_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_vld |-> (in_valid_i && !in_stall_o))
    else $error("pipeline issue without an accepted transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output transaction changed");

endmodule

`default_nettype wire
